/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the grid stepper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLGS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tlgs_pkg.sv */
// ----------------------------------------------------------------------------
// tlgs_pkg
// Shared constants, types and the cell rule of the toroidal grid stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package tlgs_pkg;

    localparam int ACTION_W      = 2;
    localparam int ROW_FIELD_W   = 3;
    localparam int COL_FIELD_W   = 4;
    // Wide enough to hold any grid dimension in its range plus one.
    localparam int DIM_EXT_W     = 9;

    localparam int DEF_GRID_ROWS = 8;
    localparam int DEF_GRID_COLS = 16;

    localparam logic [3:0] SURVIVE_COUNT = 4'd2;
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;

    // Handshake between the top-level sequencer and the generation engine.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic done;
    } t_eng_ctl;

    // B3/S23: born with three neighbours, survives with two or three.
    function automatic logic tlgs_next_cell(input logic alive, input logic [3:0] count);
        return (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
    endfunction

endpackage

`default_nettype wire

/* sv/tlgs_row_ram.sv */
// ----------------------------------------------------------------------------
// tlgs_row_ram
// Simple dual-port synchronous RAM, one grid row per word, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlgs_row_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/tlgs_gen_engine.sv */
// ----------------------------------------------------------------------------
// tlgs_gen_engine
// Streams the grid row by row through a three-row window and writes each new
// row back in place.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlgs_gen_engine #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_go,
    input  wire logic [GRID_COLS-1:0]           i_rdata,
    output tlgs_pkg::t_eng_ctl                  o_ctl,
    output logic [$clog2(GRID_ROWS)-1:0]        o_raddr,
    output logic [$clog2(GRID_ROWS)-1:0]        o_waddr,
    output logic [GRID_COLS-1:0]                o_wdata
);

    import tlgs_pkg::*;

    localparam int AW     = $clog2(GRID_ROWS);
    localparam int STEP_W = $clog2(GRID_ROWS + 4);
    localparam int LAST   = GRID_ROWS + 3;

    // Step s reads row s-1 (the last row at step zero), shifts the row read in
    // the step before into the window, and from step four writes row s-4.
    // The first row and the last row are kept aside, as both are needed again at
    // the end of the stream, when the first row may already have been overwritten.
    logic              r_run;
    logic [STEP_W-1:0] r_step;
    logic [GRID_COLS-1:0] r_up, r_mid, r_dn, r_first, r_last;
    logic [GRID_COLS-1:0] shift_in;
    logic              shift_en;

    always_comb begin
        o_ctl.rd_en = r_run && (r_step < STEP_W'(GRID_ROWS));
        o_ctl.wr_en = r_run && (r_step >= STEP_W'(4));
        o_ctl.done  = r_run && (r_step == STEP_W'(LAST));
        o_raddr     = (r_step == '0) ? AW'(GRID_ROWS - 1) : AW'(r_step - STEP_W'(1));
        o_waddr     = AW'(r_step - STEP_W'(4));
        shift_en    = r_run && (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(GRID_ROWS + 2));
        if (r_step <= STEP_W'(GRID_ROWS)) begin
            shift_in = i_rdata;
        end else if (r_step == STEP_W'(GRID_ROWS + 1)) begin
            shift_in = r_last;
        end else begin
            shift_in = r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_step <= '0;
        end else if (r_run) begin
            if (r_step == STEP_W'(LAST)) begin
                r_run <= 1'b0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= shift_in;
        end
        if (r_run && (r_step == STEP_W'(1))) begin
            r_last <= i_rdata;
        end
        if (r_run && (r_step == STEP_W'(2))) begin
            r_first <= i_rdata;
        end
    end

    // One rule evaluation per column, with the row ends wrapping around.
    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        localparam int L = (c + GRID_COLS - 1) % GRID_COLS;
        localparam int R = (c + 1) % GRID_COLS;
        logic [3:0] count;

        assign count = 4'(r_up[L]) + 4'(r_up[c]) + 4'(r_up[R])
                     + 4'(r_mid[L]) + 4'(r_mid[R])
                     + 4'(r_dn[L]) + 4'(r_dn[c]) + 4'(r_dn[R]);
        assign o_wdata[c] = tlgs_next_cell(r_mid[c], count);
    end

    // A row is always read well before it is rewritten, so the two ports never
    // meet on one row.
    `TLGS_ASSERT_IMPL(a_no_row_clash, i_clk, i_rst_n, o_ctl.rd_en && o_ctl.wr_en,
        o_raddr != o_waddr, "engine reads and writes the same row in one cycle")
    `TLGS_ASSERT_IMPL(a_go_when_idle, i_clk, i_rst_n, i_go, !r_run,
        "engine started while a generation is still in progress")
    `TLGS_ASSERT_NEXT(a_done_stops, i_clk, i_rst_n, o_ctl.done, !r_run && !o_ctl.wr_en,
        "engine keeps running after its last row")

endmodule

`default_nettype wire

/* sv/toroidal_life_generation_step.sv */
// ----------------------------------------------------------------------------
// toroidal_life_generation_step
// Conway grid (B3/S23) on a torus with cell write, cell read and advance.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge where start is high and busy is
// low, and every transaction gives exactly one result: o_done is high for one
// cycle and the receiver cannot hold it off, so it must take o_cell_alive in
// that cycle. A cell write or a cell read inside the grid reads one row from
// the grid RAM, then picks the bit out or writes the row back, and its result
// appears in the first cycle with busy low again. For an advance the grid is
// streamed one row per cycle through the single read port, and each new row
// is written back in place behind its read. A cell write or read at an
// address outside the grid, or the unused action code, returns a dead cell
// without raising busy. After reset the block sweeps the grid clear, one row
// per cycle, and holds busy high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module toroidal_life_generation_step #(
    parameter int GRID_ROWS = tlgs_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = tlgs_pkg::DEF_GRID_COLS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [tlgs_pkg::ACTION_W-1:0]      i_action,
    input  wire logic [tlgs_pkg::ROW_FIELD_W-1:0]   i_row,
    input  wire logic [tlgs_pkg::COL_FIELD_W-1:0]   i_column,
    input  wire logic                               i_alive_in,
    output logic                                    o_done,
    output logic                                    o_cell_alive
);

    import tlgs_pkg::*;

    localparam int AW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_ADV
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy, n_busy;
    logic    r_done, n_done;
    logic    r_cell, n_cell;
    logic [AW-1:0] r_clr, n_clr;

    // Transaction fields held while the row is fetched.
    t_action       r_op;
    logic [AW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic          r_alive;

    logic                 accept;
    logic                 in_grid;
    logic [DIM_EXT_W-1:0] row_ext, col_ext;
    logic [GRID_COLS-1:0] cell_row;

    // Grid RAM ports and the sequencer's own requests.
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [GRID_COLS-1:0] ram_wdata, ram_rdata;
    logic                 seq_we, seq_re;
    logic [AW-1:0]        seq_waddr, seq_raddr;
    logic [GRID_COLS-1:0] seq_wdata;

    logic                 eng_go;
    t_eng_ctl             eng_ctl;
    logic [AW-1:0]        eng_raddr, eng_waddr;
    logic [GRID_COLS-1:0] eng_wdata;

    assign accept  = start && !r_busy;
    assign row_ext = DIM_EXT_W'(i_row);
    assign col_ext = DIM_EXT_W'(i_column);
    assign in_grid = (row_ext < DIM_EXT_W'(GRID_ROWS)) && (col_ext < DIM_EXT_W'(GRID_COLS));

    // Read-modify-write of a single cell within its row.
    always_comb begin
        cell_row        = ram_rdata;
        cell_row[r_col] = r_alive;
    end

    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cell    = 1'b0;
        n_clr     = r_clr;
        seq_we    = 1'b0;
        seq_waddr = r_row;
        seq_wdata = cell_row;
        seq_re    = 1'b0;
        seq_raddr = AW'(row_ext);
        eng_go    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                seq_we    = 1'b1;
                seq_waddr = r_clr;
                seq_wdata = '0;
                if (r_clr == AW'(GRID_ROWS - 1)) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_WRITE, ACT_READ: begin
                            if (in_grid) begin
                                seq_re  = 1'b1;
                                n_state = ST_CELL;
                                n_busy  = 1'b1;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        ACT_ADVANCE: begin
                            eng_go  = 1'b1;
                            n_state = ST_ADV;
                            n_busy  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_CELL: begin
                if (r_op == ACT_WRITE) begin
                    seq_we = 1'b1;
                end else begin
                    n_cell = ram_rdata[r_col];
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
            ST_ADV: begin
                if (eng_ctl.done) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_cell  <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_cell  <= n_cell;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_action'(i_action);
            r_row   <= AW'(row_ext);
            r_col   <= CW'(col_ext);
            r_alive <= i_alive_in;
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_cell_alive = r_cell;

    // The engine only drives the RAM while an advance is in progress.
    assign ram_re    = seq_re || eng_ctl.rd_en;
    assign ram_raddr = eng_ctl.rd_en ? eng_raddr : seq_raddr;
    assign ram_we    = seq_we || eng_ctl.wr_en;
    assign ram_waddr = eng_ctl.wr_en ? eng_waddr : seq_waddr;
    assign ram_wdata = eng_ctl.wr_en ? eng_wdata : seq_wdata;

    tlgs_row_ram #(
        .DEPTH (GRID_ROWS),
        .WIDTH (GRID_COLS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tlgs_gen_engine #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_gen_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (eng_go),
        .i_rdata (ram_rdata),
        .o_ctl   (eng_ctl),
        .o_raddr (eng_raddr),
        .o_waddr (eng_waddr),
        .o_wdata (eng_wdata)
    );

    // A result is only ever presented once the block is free again.
    `TLGS_ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, o_done, !busy,
        "result presented while the block is still busy")
    // Only a read can return a live cell.
    `TLGS_ASSERT_IMPL(a_cell_with_done, i_clk, i_rst_n, o_cell_alive, o_done,
        "live cell reported without a result strobe")
    `TLGS_ASSERT_NEXT(a_adv_holds_busy, i_clk, i_rst_n,
        accept && (t_action'(i_action) == ACT_ADVANCE), busy && !o_done,
        "advance did not hold the block busy")
    // The sequencer and the engine never claim the RAM in the same cycle.
    `TLGS_ASSERT_IMPL(a_port_owner, i_clk, i_rst_n, eng_ctl.rd_en || eng_ctl.wr_en,
        !seq_re && !seq_we, "grid RAM claimed by sequencer and engine together")

endmodule

`default_nettype wire
